[design/bti_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bti_pkg;

    localparam int DEF_MAX_X_POINTS = 16;
    localparam int DEF_MAX_Y_POINTS = 16;
    localparam int CNT_REG_W        = 5;
    localparam int CFG_IDX_W        = 1;
    localparam int NUM_W            = 97;
    localparam int DIV_CNT_W        = 7;
    localparam int QUO_W            = 33;

    typedef enum logic [1:0] {
        OP_LOAD_X    = 2'd0,
        OP_LOAD_Y    = 2'd1,
        OP_LOAD_GRID = 2'd2,
        OP_QUERY     = 2'd3
    } op_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_POINTS = 1'b0,
        REG_Y_POINTS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        op_code_t           operation;
        logic [3:0]         column;
        logic [3:0]         row;
        logic signed [31:0] load_value;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               x_outside;
        logic               y_outside;
        logic               saturated;
    } out_word_t;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_RD_FIRST,
        DP_RD_LAST,
        DP_SET_P1,
        DP_SET_PLAST,
        DP_RD_HINT,
        DP_RD_PM1,
        DP_INC_RD,
        DP_DEC_RD,
        DP_DEC_P,
        DP_COMMIT,
        DP_FETCH,
        DP_PREP,
        DP_QMAG,
        DP_DEGEN,
        DP_MUL,
        DP_DMUL,
        DP_DLAT,
        DP_DIV,
        DP_ROUND,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic       accept;
        dp_op_t     op;
        logic       axis;
        logic [1:0] idx;
        logic [2:0] phase;
    } dp_cmd_t;

    typedef struct packed {
        logic le;
        logic ge;
        logic lt;
        logic gt;
        logic p_gt1;
        logic p_gt2;
        logic p_lt_last;
        logic degen;
        logic out_busy;
    } dp_status_t;

endpackage
`default_nettype wire

[design/bti_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module bti_datapath import bti_pkg::*; #(
    parameter int MAX_X_POINTS = DEF_MAX_X_POINTS,
    parameter int MAX_Y_POINTS = DEF_MAX_Y_POINTS
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  in_word_t             s_word,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CNT_REG_W-1:0]  cfg_wdata,
    output logic                 m_valid,
    input  wire                  m_ready,
    output out_word_t            m_word
);

    localparam int XI_W       = $clog2(MAX_X_POINTS);
    localparam int YI_W       = $clog2(MAX_Y_POINTS);
    localparam int PI_W       = (XI_W > YI_W) ? XI_W : YI_W;
    localparam int CNT_W      = PI_W + 1;
    localparam int GRID_DEPTH = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int GA_W       = $clog2(GRID_DEPTH);
    localparam int ACC_W      = NUM_W + 2;
    localparam int TERM_W     = 96;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] n;
        n = -v;
        return v[31] ? n : v;
    endfunction

    // storage
    logic signed [31:0] x_bp_reg [MAX_X_POINTS];
    logic signed [31:0] y_bp_reg [MAX_Y_POINTS];
    logic signed [31:0] grid_reg [GRID_DEPTH];
    logic signed [31:0] x_q_reg, y_q_reg, g_q_reg;

    logic [CNT_REG_W-1:0] x_cnt_reg, y_cnt_reg;
    logic signed [31:0]   qx_reg, qy_reg;
    logic [PI_W-1:0]      p_reg;
    logic                 out_flag_reg;
    logic [XI_W-1:0]      x_hint_reg, xp_reg;
    logic [YI_W-1:0]      y_hint_reg, yp_reg;
    logic                 xo_reg, yo_reg;

    logic                 fvalid_reg;
    logic [1:0]           fidx_reg;
    logic signed [31:0]   x0_reg, x1_reg, y0_reg, y1_reg;
    logic signed [31:0]   q_reg [4];
    logic [31:0]          mq_reg [4];
    logic [3:0]           sq_reg;

    logic [31:0] mdx_reg, mdy_reg, mwx0_reg, mwx1_reg, mwy0_reg, mwy1_reg;
    logic        sdx_reg, sdy_reg, swx0_reg, swx1_reg, swy0_reg, swy1_reg;
    logic        degen_reg;

    logic [63:0]           prod_reg;
    logic [31:0]           phi_reg;
    logic [TERM_W-1:0]     term_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [63:0]           d_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [63:0]           rem_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic                  ovf_reg;
    logic                  neg_reg;
    logic signed [31:0]    res_reg;
    logic                  sat_reg;

    logic      m_valid_reg;
    out_word_t m_word_reg;

    // combinational
    logic [CNT_W-1:0]   nx, ny, ncur;
    logic [PI_W-1:0]    last, hint_cur, hint_cl, srch_addr;
    logic signed [31:0] v, bp_q;
    logic [XI_W-1:0]    x_rd_addr, g_col;
    logic [YI_W-1:0]    y_rd_addr, g_row;
    logic [GA_W-1:0]    g_rd_addr, g_wr_addr;
    logic               x_we, y_we, g_we, is_fetch;
    logic [31:0]        mul_a, mul_b, mwx, mwy;
    logic               tneg;
    logic signed [32:0] dx_w, dy_w, wx0_w, wx1_w, wy0_w, wy1_w;
    logic [64:0]        div_r;
    logic               div_ge, rnd_bit, sat_w;
    logic [QUO_W:0]     q_rnd, limit;
    logic [31:0]        q_fin, res_mag;
    logic signed [ACC_W-1:0] acc_abs;

    always_comb begin
        if (int'(x_cnt_reg) < 2) begin
            nx = CNT_W'(2);
        end else if (int'(x_cnt_reg) > MAX_X_POINTS) begin
            nx = CNT_W'(MAX_X_POINTS);
        end else begin
            nx = CNT_W'(x_cnt_reg);
        end
        if (int'(y_cnt_reg) < 2) begin
            ny = CNT_W'(2);
        end else if (int'(y_cnt_reg) > MAX_Y_POINTS) begin
            ny = CNT_W'(MAX_Y_POINTS);
        end else begin
            ny = CNT_W'(y_cnt_reg);
        end
        ncur     = cmd.axis ? ny : nx;
        last     = PI_W'(ncur - 1'b1);
        hint_cur = cmd.axis ? PI_W'(y_hint_reg) : PI_W'(x_hint_reg);
        hint_cl  = (hint_cur > last) ? last : hint_cur;
        v        = cmd.axis ? qy_reg : qx_reg;
        bp_q     = cmd.axis ? y_q_reg : x_q_reg;
    end

    always_comb begin
        case (cmd.op)
            DP_RD_LAST: srch_addr = last;
            DP_RD_HINT: srch_addr = hint_cl;
            DP_RD_PM1:  srch_addr = p_reg - 1'b1;
            DP_INC_RD:  srch_addr = p_reg + 1'b1;
            DP_DEC_RD:  srch_addr = p_reg - PI_W'(2);
            default:    srch_addr = '0;
        endcase
        is_fetch  = (cmd.op == DP_FETCH);
        x_rd_addr = is_fetch ? (cmd.idx[0] ? xp_reg : xp_reg - 1'b1) : XI_W'(srch_addr);
        y_rd_addr = is_fetch ? (cmd.idx[0] ? yp_reg : yp_reg - 1'b1) : YI_W'(srch_addr);
        g_row     = cmd.idx[1] ? yp_reg : yp_reg - 1'b1;
        g_col     = cmd.idx[0] ? xp_reg : xp_reg - 1'b1;
        g_rd_addr = GA_W'(g_row) * GA_W'(MAX_X_POINTS) + GA_W'(g_col);
        g_wr_addr = GA_W'(s_word.row) * GA_W'(MAX_X_POINTS) + GA_W'(s_word.column);
        x_we = cmd.accept && (s_word.operation == OP_LOAD_X)
               && (int'(s_word.column) < MAX_X_POINTS);
        y_we = cmd.accept && (s_word.operation == OP_LOAD_Y)
               && (int'(s_word.row) < MAX_Y_POINTS);
        g_we = cmd.accept && (s_word.operation == OP_LOAD_GRID)
               && (int'(s_word.column) < MAX_X_POINTS)
               && (int'(s_word.row) < MAX_Y_POINTS);
    end

    always_ff @(posedge aclk) begin
        if (x_we) begin
            x_bp_reg[XI_W'(s_word.column)] <= s_word.load_value;
        end
        x_q_reg <= x_bp_reg[x_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (y_we) begin
            y_bp_reg[YI_W'(s_word.row)] <= s_word.load_value;
        end
        y_q_reg <= y_bp_reg[y_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (g_we) begin
            grid_reg[g_wr_addr] <= s_word.load_value;
        end
        g_q_reg <= grid_reg[g_rd_addr];
    end

    always_comb begin
        status.le        = (v <= bp_q);
        status.ge        = (v >= bp_q);
        status.lt        = (v < bp_q);
        status.gt        = (v > bp_q);
        status.p_gt1     = (int'(p_reg) > 1);
        status.p_gt2     = (int'(p_reg) > 2);
        status.p_lt_last = (p_reg < last);
        status.degen     = degen_reg;
        status.out_busy  = m_valid_reg && !m_ready;
    end

    // arithmetic selection
    always_comb begin
        dx_w  = 33'(x1_reg) - 33'(x0_reg);
        dy_w  = 33'(y1_reg) - 33'(y0_reg);
        wx1_w = 33'(x1_reg) - 33'(qx_reg);
        wx0_w = 33'(qx_reg) - 33'(x0_reg);
        wy1_w = 33'(y1_reg) - 33'(qy_reg);
        wy0_w = 33'(qy_reg) - 33'(y0_reg);
        mwx   = cmd.idx[0] ? mwx0_reg : mwx1_reg;
        mwy   = cmd.idx[1] ? mwy0_reg : mwy1_reg;
        tneg  = sq_reg[cmd.idx] ^ (cmd.idx[0] ? swx0_reg : swx1_reg)
                ^ (cmd.idx[1] ? swy0_reg : swy1_reg);
        mul_a = '0;
        mul_b = '0;
        if (cmd.op == DP_MUL) begin
            case (cmd.phase)
                3'd0: begin
                    mul_a = mq_reg[cmd.idx];
                    mul_b = mwx;
                end
                3'd1: begin
                    mul_a = prod_reg[31:0];
                    mul_b = mwy;
                end
                3'd2: begin
                    mul_a = phi_reg;
                    mul_b = mwy;
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else if (cmd.op == DP_DMUL) begin
            mul_a = mdx_reg;
            mul_b = mdy_reg;
        end
        acc_abs = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
        div_r   = {rem_reg, num_reg[NUM_W-1]};
        div_ge  = (div_r >= {1'b0, d_reg});
        rnd_bit = ({rem_reg, 1'b0} >= {1'b0, d_reg});
        q_rnd   = {1'b0, quo_reg} + (QUO_W + 1)'(rnd_bit);
        limit   = neg_reg ? (QUO_W + 1)'(34'h080000000) : (QUO_W + 1)'(34'h07FFFFFFF);
        sat_w   = ovf_reg || (q_rnd > limit);
        q_fin   = sat_w ? limit[31:0] : q_rnd[31:0];
        res_mag = -q_fin;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.accept) begin
            qx_reg <= s_word.query_x;
            qy_reg <= s_word.query_y;
        end
        case (cmd.op)
            DP_SET_P1: begin
                p_reg        <= PI_W'(1);
                out_flag_reg <= 1'b1;
            end
            DP_SET_PLAST: begin
                p_reg        <= last;
                out_flag_reg <= 1'b1;
            end
            DP_RD_HINT: begin
                p_reg        <= hint_cl;
                out_flag_reg <= 1'b0;
            end
            DP_INC_RD: p_reg <= p_reg + 1'b1;
            DP_DEC_RD: p_reg <= p_reg - 1'b1;
            DP_DEC_P:  p_reg <= p_reg - 1'b1;
            DP_COMMIT: begin
                if (cmd.axis) begin
                    yp_reg <= YI_W'(p_reg);
                    yo_reg <= out_flag_reg;
                end else begin
                    xp_reg <= XI_W'(p_reg);
                    xo_reg <= out_flag_reg;
                end
            end
            DP_PREP: begin
                mdx_reg   <= mag33(dx_w);
                mdy_reg   <= mag33(dy_w);
                mwx0_reg  <= mag33(wx0_w);
                mwx1_reg  <= mag33(wx1_w);
                mwy0_reg  <= mag33(wy0_w);
                mwy1_reg  <= mag33(wy1_w);
                sdx_reg   <= dx_w[32];
                sdy_reg   <= dy_w[32];
                swx0_reg  <= wx0_w[32];
                swx1_reg  <= wx1_w[32];
                swy0_reg  <= wy0_w[32];
                swy1_reg  <= wy1_w[32];
                degen_reg <= (dx_w == '0) || (dy_w == '0);
                acc_reg   <= '0;
            end
            DP_QMAG: begin
                for (int i = 0; i < 4; i++) begin
                    mq_reg[i] <= mag32(q_reg[i]);
                    sq_reg[i] <= q_reg[i][31];
                end
            end
            DP_DEGEN: begin
                res_reg <= q_reg[0];
                sat_reg <= 1'b0;
            end
            DP_MUL: begin
                case (cmd.phase)
                    3'd1: phi_reg <= prod_reg[63:32];
                    3'd2: term_reg <= TERM_W'(prod_reg);
                    3'd3: term_reg <= term_reg + {prod_reg, 32'b0};
                    3'd4: acc_reg <= tneg ? acc_reg - ACC_W'(term_reg)
                                          : acc_reg + ACC_W'(term_reg);
                    default: phi_reg <= phi_reg;
                endcase
            end
            DP_DLAT: begin
                d_reg   <= prod_reg;
                num_reg <= acc_abs[NUM_W-1:0];
                neg_reg <= acc_reg[ACC_W-1] ^ sdx_reg ^ sdy_reg;
                rem_reg <= '0;
                quo_reg <= '0;
                ovf_reg <= 1'b0;
            end
            DP_DIV: begin
                rem_reg <= div_ge ? 64'(div_r - {1'b0, d_reg}) : div_r[63:0];
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_W-2:0], div_ge};
                ovf_reg <= ovf_reg | quo_reg[QUO_W-1];
            end
            DP_ROUND: begin
                res_reg <= neg_reg ? res_mag : q_fin;
                sat_reg <= sat_w;
            end
            default: begin
                p_reg <= p_reg;
            end
        endcase
        if (fvalid_reg) begin
            q_reg[fidx_reg] <= g_q_reg;
            case (fidx_reg)
                2'd0: begin
                    x0_reg <= x_q_reg;
                    y0_reg <= y_q_reg;
                end
                2'd1: begin
                    x1_reg <= x_q_reg;
                    y1_reg <= y_q_reg;
                end
                default: begin
                    x0_reg <= x0_reg;
                end
            endcase
        end
        fidx_reg <= cmd.idx;
        if (cmd.op == DP_EMIT) begin
            m_word_reg <= '{result: res_reg, x_outside: xo_reg,
                            y_outside: yo_reg, saturated: sat_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_cnt_reg   <= CNT_REG_W'(2);
            y_cnt_reg   <= CNT_REG_W'(2);
            x_hint_reg  <= '0;
            y_hint_reg  <= '0;
            fvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_X_POINTS: x_cnt_reg <= cfg_wdata;
                    REG_Y_POINTS: y_cnt_reg <= cfg_wdata;
                    default:      x_cnt_reg <= x_cnt_reg;
                endcase
            end
            if (cmd.op == DP_COMMIT) begin
                if (cmd.axis) begin
                    y_hint_reg <= YI_W'(p_reg);
                end else begin
                    x_hint_reg <= XI_W'(p_reg);
                end
            end
            fvalid_reg <= is_fetch;
            if (cmd.op == DP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_word    = m_word_reg;

endmodule
`default_nettype wire

[design/bti_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
module bti_controller import bti_pkg::*; (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    input  op_code_t   s_op,
    output logic       s_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam logic [2:0]           LAST_PHASE = 3'd4;
    localparam logic [1:0]           LAST_TERM  = 2'd3;
    localparam logic [1:0]           LAST_FETCH = 2'd3;
    localparam logic [DIV_CNT_W-1:0] LAST_DIV   = DIV_CNT_W'(NUM_W - 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_F0, ST_F0C, ST_LC, ST_HC, ST_UC, ST_DC, ST_COMMIT,
        ST_FETCH, ST_PREP, ST_QMAG, ST_MUL, ST_DMUL, ST_DLAT, ST_DIV,
        ST_ROUND, ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic                  axis_reg, axis_next;
    logic [1:0]            fidx_reg, fidx_next;
    logic [1:0]            term_reg, term_next;
    logic [2:0]            phase_reg, phase_next;
    logic [DIV_CNT_W-1:0]  dcnt_reg, dcnt_next;

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        fidx_next  = fidx_reg;
        term_next  = term_reg;
        phase_next = phase_reg;
        dcnt_next  = dcnt_reg;
        cmd.accept = s_valid && (state_reg == ST_IDLE);
        cmd.op     = DP_NONE;
        cmd.axis   = axis_reg;
        cmd.idx    = (state_reg == ST_FETCH) ? fidx_reg : term_reg;
        cmd.phase  = phase_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_op == OP_QUERY)) begin
                    state_next = ST_F0;
                    axis_next  = 1'b0;
                end
            end
            ST_F0: begin
                cmd.op     = DP_RD_FIRST;
                state_next = ST_F0C;
            end
            ST_F0C: begin
                if (status.le) begin
                    cmd.op     = DP_SET_P1;
                    state_next = ST_COMMIT;
                end else begin
                    cmd.op     = DP_RD_LAST;
                    state_next = ST_LC;
                end
            end
            ST_LC: begin
                if (status.ge) begin
                    cmd.op     = DP_SET_PLAST;
                    state_next = ST_COMMIT;
                end else begin
                    cmd.op     = DP_RD_HINT;
                    state_next = ST_HC;
                end
            end
            ST_HC: begin
                if (status.lt && status.p_gt1) begin
                    cmd.op     = DP_RD_PM1;
                    state_next = ST_DC;
                end else if (status.gt && status.p_lt_last) begin
                    cmd.op     = DP_INC_RD;
                    state_next = ST_UC;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_UC: begin
                if (status.gt && status.p_lt_last) begin
                    cmd.op = DP_INC_RD;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DC: begin
                if (status.lt && status.p_gt2) begin
                    cmd.op = DP_DEC_RD;
                end else if (status.lt) begin
                    cmd.op     = DP_DEC_P;
                    state_next = ST_COMMIT;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.op = DP_COMMIT;
                if (!axis_reg) begin
                    axis_next  = 1'b1;
                    state_next = ST_F0;
                end else begin
                    fidx_next  = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.op    = DP_FETCH;
                fidx_next = fidx_reg + 1'b1;
                if (fidx_reg == LAST_FETCH) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.op     = DP_PREP;
                state_next = ST_QMAG;
            end
            ST_QMAG: begin
                if (status.degen) begin
                    cmd.op     = DP_DEGEN;
                    state_next = ST_DONE;
                end else begin
                    cmd.op     = DP_QMAG;
                    term_next  = '0;
                    phase_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.op = DP_MUL;
                if (phase_reg == LAST_PHASE) begin
                    phase_next = '0;
                    term_next  = term_reg + 1'b1;
                    if (term_reg == LAST_TERM) begin
                        state_next = ST_DMUL;
                    end
                end else begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            ST_DMUL: begin
                cmd.op     = DP_DMUL;
                state_next = ST_DLAT;
            end
            ST_DLAT: begin
                cmd.op     = DP_DLAT;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op    = DP_DIV;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == LAST_DIV) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.op     = DP_ROUND;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.op     = DP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
            fidx_reg  <= '0;
            term_reg  <= '0;
            phase_reg <= '0;
            dcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            fidx_reg  <= fidx_next;
            term_reg  <= term_next;
            phase_reg <= phase_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

[design/bilinear_table_interpolator.sv]
// Loads: one word per cycle while no query is in progress, no result.
// Query: the bit-serial divider sets most of the time from acceptance to result, and the
// segment walk adds time for each breakpoint stepped; a flat cell skips multiply and divide.
// One query in flight at a time; a waiting result holds back the next query's result, not its acceptance.
// Reset: synchronous, active-low aresetn clears control, hints and counts (to 2);
// breakpoint and grid tables hold no reset value and are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_table_interpolator import bti_pkg::*; #(
    parameter int MAX_X_POINTS = DEF_MAX_X_POINTS,
    parameter int MAX_Y_POINTS = DEF_MAX_Y_POINTS
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  in_word_t            s_word,
    output logic                m_valid,
    input  wire                 m_ready,
    output out_word_t           m_word,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [CFG_IDX_W-1:0] cfg_index,
    input  wire [CNT_REG_W-1:0] cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    bti_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_word.operation),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    bti_datapath #(
        .MAX_X_POINTS (MAX_X_POINTS),
        .MAX_Y_POINTS (MAX_Y_POINTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_word    (s_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_word.operation != OP_QUERY) && !m_valid) |=> !m_valid)
        else $error("load word produced a result");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_word.operation == OP_QUERY)) |=> !s_ready)
        else $error("input taken while a query is in progress");

    a_result_from_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised without a query in progress");

endmodule
`default_nettype wire
